// File: hdl/sbs_pkg.sv
package sbs_pkg;

    // Command codes carried on the tick channel
    typedef enum logic [1:0] {
        CMD_START_WRITE = 2'd0,
        CMD_READ        = 2'd1,
        CMD_WRITE       = 2'd2,
        CMD_STOP        = 2'd3
    } t_cmd;

    // Bus phase, one-hot
    typedef enum logic [22:0] {
        PH_IDLE  = 23'h000001,
        PH_S1    = 23'h000002,
        PH_S2    = 23'h000004,
        PH_S3    = 23'h000008,
        PH_S4    = 23'h000010,
        PH_WBIT  = 23'h000020,
        PH_WCH   = 23'h000040,
        PH_WWAIT = 23'h000080,
        PH_WA1   = 23'h000100,
        PH_WA2   = 23'h000200,
        PH_WA3   = 23'h000400,
        PH_WA4   = 23'h000800,
        PH_R0    = 23'h001000,
        PH_RCH   = 23'h002000,
        PH_RWAIT = 23'h004000,
        PH_RA1   = 23'h008000,
        PH_RA2   = 23'h010000,
        PH_RA3   = 23'h020000,
        PH_RA4   = 23'h040000,
        PH_SP1   = 23'h080000,
        PH_SP2   = 23'h100000,
        PH_SP3   = 23'h200000,
        PH_SP4   = 23'h400000
    } t_phase;

    // Read/write bit of the address byte
    localparam logic [7:0] READ_BIT = 8'h01;

    // Classified tick, queued between front and back
    typedef struct packed {
        logic       cmd_valid;
        t_phase     entry_phase;
        logic       load_shift;
        logic [7:0] load_byte;
        logic       read_pending;
        logic       clock_sense;
        logic       data_sense;
    } t_job;

endpackage

// File: hdl/sbs_if.sv
// Tick channel: one bus tick per transfer
interface sbs_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [1:0] cmd;
    logic [7:0] byte_in;
    logic       clock_sense;
    logic       data_sense;

    modport source(output valid, output cmd_valid, output cmd, output byte_in,
                   output clock_sense, output data_sense, input ready);
    modport sink(input valid, input cmd_valid, input cmd, input byte_in,
                 input clock_sense, input data_sense, output ready);
endinterface

// Result channel: pin levels and status after each tick
interface sbs_res_if;
    logic       valid;
    logic       ready;
    logic       clock_release;
    logic       data_release;
    logic       busy_res;
    logic       cmd_taken;
    logic       read_valid;
    logic [7:0] read_byte;

    modport source(output valid, output clock_release, output data_release,
                   output busy_res, output cmd_taken, output read_valid,
                   output read_byte, input ready);
    modport sink(input valid, input clock_release, input data_release,
                 input busy_res, input cmd_taken, input read_valid,
                 input read_byte, output ready);
endinterface

// File: hdl/sbs_front.sv
module sbs_front
    import sbs_pkg::*;
(
    sbs_tick_if.sink i_tick,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);

    assign i_tick.ready = !i_full;
    assign o_push       = i_tick.valid && !i_full;

    // Work out where each command enters the phase sequence
    always_comb begin
        o_job.cmd_valid    = i_tick.cmd_valid;
        o_job.clock_sense  = i_tick.clock_sense;
        o_job.data_sense   = i_tick.data_sense;
        o_job.load_byte    = i_tick.byte_in;
        o_job.load_shift   = 1'b1;
        o_job.read_pending = 1'b0;
        unique case (t_cmd'(i_tick.cmd))
            CMD_START_WRITE: o_job.entry_phase = PH_S1;
            CMD_READ: begin
                o_job.entry_phase  = PH_S1;
                o_job.load_byte    = i_tick.byte_in | READ_BIT;
                o_job.read_pending = 1'b1;
            end
            CMD_WRITE:       o_job.entry_phase = PH_WBIT;
            CMD_STOP: begin
                o_job.entry_phase = PH_SP1;
                o_job.load_shift  = 1'b0;
            end
            default:         o_job.entry_phase = PH_IDLE;
        endcase
    end

endmodule

// File: hdl/sbs_queue.sv
module sbs_queue
    import sbs_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_next(r_rd_ptr);
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

// File: hdl/sbs_back.sv
module sbs_back
    import sbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    sbs_res_if.source o_res
);

    t_phase     r_phase, n_phase;
    logic [2:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift, n_shift;
    logic       r_read_pending, n_read_pending;
    logic       r_clk_drv, n_clk_drv;
    logic       r_dat_drv, n_dat_drv;

    logic       r_out_valid;
    logic       r_taken, r_rvalid;
    logic [7:0] r_rbyte;
    t_phase     ph;
    logic       taken;
    logic       rvalid;
    logic [7:0] rbyte;
    logic [2:0] bc_inc;

    assign o_pop = i_job_valid && (!r_out_valid || o_res.ready);

    always_comb begin
        taken          = (r_phase == PH_IDLE) && i_job.cmd_valid;
        ph             = r_phase;
        n_shift        = r_shift;
        n_bit_count    = r_bit_count;
        n_read_pending = r_read_pending;
        n_clk_drv      = r_clk_drv;
        n_dat_drv      = r_dat_drv;
        rvalid         = 1'b0;
        rbyte          = '0;
        if (taken) begin
            n_bit_count    = '0;
            ph             = i_job.entry_phase;
            n_read_pending = i_job.read_pending;
            if (i_job.load_shift) n_shift = i_job.load_byte;
        end
        bc_inc  = n_bit_count + 3'd1;
        n_phase = ph;
        unique case (ph)
            PH_IDLE: ;
            PH_S1:   begin n_clk_drv = 1'b1; n_phase = PH_S2; end
            PH_S2:   begin n_dat_drv = 1'b1; n_phase = PH_S3; end
            PH_S3:   begin n_dat_drv = 1'b0; n_phase = PH_S4; end
            PH_S4:   begin n_clk_drv = 1'b0; n_phase = PH_WBIT; end
            PH_WBIT: begin
                n_dat_drv = n_shift[7];
                n_shift   = {n_shift[6:0], 1'b0};
                n_phase   = PH_WCH;
            end
            PH_WCH:  begin n_clk_drv = 1'b1; n_phase = PH_WWAIT; end
            PH_WWAIT: begin
                // hold while the slave stretches the clock
                if (i_job.clock_sense) begin
                    n_clk_drv   = 1'b0;
                    n_bit_count = bc_inc;
                    n_phase     = (bc_inc == '0) ? PH_WA1 : PH_WBIT;
                end
            end
            PH_WA1:  begin n_dat_drv = 1'b1; n_phase = PH_WA2; end
            PH_WA2:  begin n_clk_drv = 1'b1; n_phase = PH_WA3; end
            PH_WA3:  begin n_dat_drv = 1'b0; n_phase = PH_WA4; end
            PH_WA4: begin
                n_clk_drv = 1'b0;
                n_phase   = n_read_pending ? PH_R0 : PH_IDLE;
            end
            PH_R0:   begin n_dat_drv = 1'b1; n_phase = PH_RCH; end
            PH_RCH:  begin n_clk_drv = 1'b1; n_phase = PH_RWAIT; end
            PH_RWAIT: begin
                if (i_job.clock_sense) begin
                    n_shift     = {n_shift[6:0], i_job.data_sense};
                    n_clk_drv   = 1'b0;
                    n_bit_count = bc_inc;
                    if (bc_inc == '0) begin
                        rvalid  = 1'b1;
                        rbyte   = n_shift;
                        n_phase = PH_RA1;
                    end else begin
                        n_phase = PH_RCH;
                    end
                end
            end
            PH_RA1:  begin n_dat_drv = 1'b1; n_phase = PH_RA2; end
            PH_RA2:  begin n_clk_drv = 1'b1; n_phase = PH_RA3; end
            PH_RA3:  begin n_clk_drv = 1'b0; n_phase = PH_RA4; end
            PH_RA4:  begin n_dat_drv = 1'b0; n_phase = PH_SP1; end
            PH_SP1:  begin n_clk_drv = 1'b0; n_phase = PH_SP2; end
            PH_SP2:  begin n_dat_drv = 1'b0; n_phase = PH_SP3; end
            PH_SP3:  begin n_clk_drv = 1'b1; n_phase = PH_SP4; end
            PH_SP4: begin
                n_dat_drv      = 1'b1;
                n_read_pending = 1'b0;
                n_phase        = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_count    <= '0;
            r_shift        <= '0;
            r_read_pending <= 1'b0;
            r_clk_drv      <= 1'b1;
            r_dat_drv      <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase        <= n_phase;
                r_bit_count    <= n_bit_count;
                r_shift        <= n_shift;
                r_read_pending <= n_read_pending;
                r_clk_drv      <= n_clk_drv;
                r_dat_drv      <= n_dat_drv;
                r_out_valid    <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-tick status, loaded with the pin state
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_taken  <= taken;
            r_rvalid <= rvalid;
            r_rbyte  <= rbyte;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.clock_release = r_clk_drv;
    assign o_res.data_release  = r_dat_drv;
    assign o_res.busy_res      = (r_phase != PH_IDLE);
    assign o_res.cmd_taken     = r_taken;
    assign o_res.read_valid    = r_rvalid;
    assign o_res.read_byte     = r_rbyte;

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_job_valid)
        else $error("pop from an empty queue");

    a_taken_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_taken) |-> o_res.busy_res)
        else $error("accepted command left the sequencer idle");

    a_read_in_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && rvalid) |=> (r_phase == PH_RA1 && r_clk_drv == 1'b0))
        else $error("read byte completed outside the acknowledge entry");

    a_rbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_rvalid) |-> (r_rbyte == '0))
        else $error("read byte not cleared without read_valid");

endmodule

// File: hdl/sccb_master_bit_sequencer_core.sv
// SCCB master bit sequencer. Each transfer on i_tick is one bus tick and
// yields exactly one transfer on o_res carrying the open-drain pin levels
// (1 = released) after that tick plus busy, command-taken and read status.
// Commands: start plus write address, a complete one-byte read (start,
// address with the read bit forced, eight sampled bits, NACK, stop), a write
// data byte, or stop. A command is taken only when the sequencer is idle;
// otherwise it is dropped and cmd_taken stays low. Clock stretching is
// honoured by holding the phase while clock_sense is low after a release.
// Rate: one tick per clock while o_res.ready stays high. The front decodes
// ticks into a short queue; the back runs one phase step per tick from the
// queue into the result register, so a tick's result passes through the
// queue and then the result register before it is presented on o_res.
// A stalled result register backs up into the queue and only then drops
// i_tick.ready. No clearing pass after reset.
module sccb_master_bit_sequencer_core
    import sbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbs_tick_if.sink  i_tick,
    sbs_res_if.source o_res
);

    logic q_push, q_pop, q_full, q_empty;
    t_job job_in, job_out;

    // Decode and classify
    sbs_front u_front (
        .i_tick (i_tick),
        .i_full (q_full),
        .o_push (q_push),
        .o_job  (job_in)
    );

    // Decoupling queue between front and back
    sbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (job_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (job_out),
        .o_empty     (q_empty)
    );

    // Phase sequencer and result register
    sbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (job_out),
        .o_pop       (q_pop),
        .o_res       (o_res)
    );

endmodule
